@@ src/dsbg_pkg.sv @@
// Constants and tables shared by the damped sine burst generator.
`default_nettype none

package dsbg_pkg;

  localparam int BURST_LENGTH = 64;
  localparam int IDX_W        = $clog2(BURST_LENGTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BURST_LENGTH - 1);

  localparam int SEV_W  = 8;
  localparam int AMP_W  = 15;   // severity * 128, at most 32640
  localparam int MAG_W  = 7;    // Q7 sine magnitude
  localparam int PROD_W = AMP_W + MAG_W;
  localparam int CODE_W = 16;

  localparam logic [CODE_W-1:0] MID_SCALE = 16'h8000;
  localparam logic [PROD_W-1:0] SINE_FULL = PROD_W'(127);

  // floor(2^21 / 127); the estimate it gives is low by at most one.
  localparam int RECIP_SHIFT = 21;
  localparam logic [14:0] RECIP_127 = 15'd16513;

  typedef logic [MAG_W-1:0] sine_mag_t [8];
  typedef logic             sine_neg_t [8];

  localparam sine_mag_t SINE_MAG = '{7'd0, 7'd90, 7'd127, 7'd90,
                                     7'd0, 7'd90, 7'd127, 7'd90};
  localparam sine_neg_t SINE_NEG = '{1'b0, 1'b0, 1'b0, 1'b0,
                                     1'b0, 1'b1, 1'b1, 1'b1};

endpackage

`default_nettype wire

@@ src/damped_sine_burst_generator.sv @@
// Top level of the damped sine burst generator: burst sequencer and sample pipeline.
//
//   channel   signals                       handshake
//   trigger   start, severity, busy         taken when start is high and busy is low
//   samples   strobe, dac_code, last_sample one cycle each, no back-pressure
//
// A trigger yields BURST_LENGTH samples, one per clock; the first passes through the
// sequencer, stage A, stage B and the output registers after the request is taken.
// The decay register updates once a cycle. Busy drops in the cycle of the final
// sample of the sequencer, so bursts can follow each other gap-free.
// Reset (rst, synchronous) idles the sequencer and clears the pipeline strobes.
`default_nettype none

module damped_sine_burst_generator (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire [dsbg_pkg::SEV_W-1:0]    severity,
  output logic                         busy,
  output logic                         strobe,
  output logic [dsbg_pkg::CODE_W-1:0]  dac_code,
  output logic                         last_sample
);
  import dsbg_pkg::*;

  // Sequencer.
  logic             active;
  logic [IDX_W-1:0] idx;
  logic [AMP_W-1:0] amp;
  logic [AMP_W+3:0] amp_x15;
  logic [AMP_W-1:0] amp_next;
  logic             accept;
  logic             seq_last;

  // Stage A: sine magnitude times amplitude.
  logic              a_vld;
  logic              a_neg;
  logic              a_last;
  logic [PROD_W-1:0] a_prod;

  // Stage B: quotient estimate.
  logic              b_vld;
  logic              b_neg;
  logic              b_last;
  logic [PROD_W-1:0] b_prod;
  logic [AMP_W-1:0]  b_q;

  logic [PROD_W+14:0] recip_prod;
  logic [PROD_W-1:0]  q_x127;
  logic [PROD_W-1:0]  rem;
  logic [AMP_W-1:0]   q_fix;
  logic [CODE_W-1:0]  dev;
  logic [CODE_W-1:0]  code_next;

  assign seq_last = (idx == LAST_IDX);
  assign busy     = active && !seq_last;
  assign accept   = start && !busy;

  assign amp_x15  = {amp, 4'b0000} - {4'b0000, amp};
  assign amp_next = amp_x15[AMP_W+3:4];

  assign recip_prod = (PROD_W+15)'(a_prod) * (PROD_W+15)'(RECIP_127);

  // The estimate is floor(x/127) or one below it; one compare fixes it.
  assign q_x127    = {b_q, 7'b0000000} - {7'b0000000, b_q};
  assign rem       = b_prod - q_x127;
  assign q_fix     = (rem >= SINE_FULL) ? b_q + AMP_W'(1) : b_q;
  assign dev       = b_neg ? -{1'b0, q_fix} : {1'b0, q_fix};
  assign code_next = b_last ? MID_SCALE : MID_SCALE + dev;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
      a_vld  <= 1'b0;
      b_vld  <= 1'b0;
      strobe <= 1'b0;
    end else begin
      if (accept) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (active) begin
        active <= !seq_last;
        idx    <= idx + IDX_W'(1);
      end
      a_vld  <= active;
      b_vld  <= a_vld;
      strobe <= b_vld;
    end

    if (accept) begin
      amp <= {severity, 7'b0000000};
    end else begin
      amp <= amp_next;
    end

    a_prod <= PROD_W'(SINE_MAG[idx[2:0]]) * PROD_W'(amp);
    a_neg  <= SINE_NEG[idx[2:0]];
    a_last <= seq_last;

    b_prod <= a_prod;
    b_q    <= recip_prod[RECIP_SHIFT+AMP_W-1:RECIP_SHIFT];
    b_neg  <= a_neg;
    b_last <= a_last;

    dac_code    <= code_next;
    last_sample <= b_last;
  end

endmodule

`default_nettype wire
